@@ hw/rtl/sha512_pkg.sv @@
// ============================================================================
// SHA-512 hash core package
// Shared types, round constants, initial hash values and the sigma functions
// used by the round unit and the message schedule.
// ============================================================================
package sha512_pkg;

  typedef logic [63:0]      word_t;
  typedef logic [7:0][63:0] work_t;

  localparam int ROUNDS         = 80;
  localparam int BLOCK_WORDS    = 16;
  localparam int LEN_FIELD_BITS = 128;
  localparam int RCNT_W         = $clog2(ROUNDS);

  localparam logic [3:0]  FILL_LAST     = 4'(BLOCK_WORDS - 1);
  localparam logic [3:0]  FILL_LEN_SLOT = 4'(BLOCK_WORDS - 2);
  localparam logic [3:0]  FULL_BYTES    = 4'd8;
  localparam logic [7:0]  PAD_MARK_BYTE = 8'h80;
  localparam logic [2:0]  LAST_IDX_512  = 3'd7;
  localparam logic [2:0]  LAST_IDX_384  = 3'd5;
  localparam logic [RCNT_W-1:0] RCNT_LAST = RCNT_W'(ROUNDS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    PAD_MARK,
    PAD_ZERO,
    PAD_LEN_LO,
    PAD_DONE
  } pad_step_t;

  // Control from the sequencer to the message schedule.
  typedef struct packed {
    logic shift;   // advance the window by one word
    logic expand;  // shift in the expanded word instead of the appended one
  } sched_ctl_t;

  localparam word_t ROUND_K [ROUNDS] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  localparam work_t IV_512 = {
    64'h5be0cd19137e2179, 64'h1f83d9abfb41bd6b, 64'h9b05688c2b3e6c1f, 64'h510e527fade682d1,
    64'ha54ff53a5f1d36f1, 64'h3c6ef372fe94f82b, 64'hbb67ae8584caa73b, 64'h6a09e667f3bcc908
  };

  localparam work_t IV_384 = {
    64'h47b5481dbefa4fa4, 64'hdb0c2e0d64f98fa7, 64'h8eb44a8768581511, 64'h67332667ffc00b31,
    64'h152fecd8f70e5939, 64'h9159015a3070dd17, 64'h629a292a367cd507, 64'hcbbb9d5dc1059ed8
  };

  function automatic word_t rotr(input word_t x, input int s);
    return (x >> s) | (x << (64 - s));
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    return rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
  endfunction

endpackage

@@ hw/rtl/sha512_if.sv @@
// ============================================================================
// SHA-512 channel interfaces
// Valid/ready channels for message words in and digest words out.
// ============================================================================
interface sha512_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] msg_word;
  logic [3:0]  valid_bytes;
  logic        final_word;

  modport source (output valid, msg_word, valid_bytes, final_word, input ready);
  modport sink   (input valid, msg_word, valid_bytes, final_word, output ready);
endinterface

interface sha512_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic [2:0]  word_index;
  logic        digest_last;

  modport source (output valid, digest_word, word_index, digest_last, input ready);
  modport sink   (input valid, digest_word, word_index, digest_last, output ready);
endinterface

@@ hw/rtl/sha512_round.sv @@
// ============================================================================
// SHA-512 round unit
// One compression round on the eight working variables.
// ============================================================================
module sha512_round (
  input  sha512_pkg::work_t cur,
  input  sha512_pkg::word_t kt,
  input  sha512_pkg::word_t wt,
  output sha512_pkg::work_t nxt
);
  import sha512_pkg::*;

  word_t t1;
  word_t t2;
  word_t ch;
  word_t maj;

  always_comb begin
    ch  = (cur[4] & cur[5]) ^ (~cur[4] & cur[6]);
    maj = (cur[0] & cur[1]) ^ (cur[0] & cur[2]) ^ (cur[1] & cur[2]);
    t1  = cur[7] + big_sigma1(cur[4]) + ch + kt + wt;
    t2  = big_sigma0(cur[0]) + maj;
    nxt[0] = t1 + t2;
    nxt[1] = cur[0];
    nxt[2] = cur[1];
    nxt[3] = cur[2];
    nxt[4] = cur[3] + t1;
    nxt[5] = cur[4];
    nxt[6] = cur[5];
    nxt[7] = cur[6];
  end

endmodule

@@ hw/rtl/sha512_sched.sv @@
// ============================================================================
// SHA-512 message schedule
// Sixteen-word window that gathers the block and expands it during rounds.
// ============================================================================
module sha512_sched (
  input  logic                   clk,
  input  sha512_pkg::sched_ctl_t ctl,
  input  sha512_pkg::word_t      app_word,
  output sha512_pkg::word_t      wt
);
  import sha512_pkg::*;

  word_t win_r [BLOCK_WORDS];
  word_t shift_in;

  // The expanded word is W[t+16], computed from the window holding W[t..t+15].
  always_comb begin
    if (ctl.expand) begin
      shift_in = win_r[0] + small_sigma0(win_r[1]) + win_r[9] + small_sigma1(win_r[14]);
    end else begin
      shift_in = app_word;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
        win_r[i] <= win_r[i + 1];
      end
      win_r[BLOCK_WORDS - 1] <= shift_in;
    end
  end

  assign wt = win_r[0];

endmodule

@@ hw/rtl/sha512_hash_core.sv @@
// ============================================================================
// SHA-512 / SHA-384 hash core
// Word-serial message input, iterative 80-round compression with padding
// and length insertion, digest read out one word per item.
// ============================================================================
//
//  channel | dir | payload                                  | handshake
//  --------+-----+------------------------------------------+--------------
//  in_msg  | in  | msg_word[63:0], valid_bytes[3:0], final  | valid/ready
//  out_dig | out | digest_word[63:0], word_index[2:0], last | valid/ready
//  cfg     | in  | cfg_wr_data (0 = SHA-512, 1 = SHA-384)   | cfg_wr_en
//
// The sixteenth word of a block starts the shared round unit, which runs one
// round per cycle through the 80 rounds and then folds the result into the
// chain. A final word adds one pad word per cycle and one or two more
// compressions before the digest appears. Ready is high only in the idle
// state. Reset loads the SHA-512 initial values and clears the bit count.
// A stalled output holds its word; the core waits without losing state.
//
module sha512_hash_core #(
  parameter int LENGTH_COUNTER_BITS = 128
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic         cfg_wr_data,
  sha512_in_if.sink    in_msg,
  sha512_out_if.source out_dig
);
  import sha512_pkg::*;

  state_t     state_r;
  state_t     state_nxt;
  pad_step_t  step_r;
  pad_step_t  step_nxt;
  logic       mode_r;
  logic       fin_r;
  logic [3:0] fill_r;
  logic [2:0] idx_r;
  logic [RCNT_W-1:0] rcnt_r;
  logic [LENGTH_COUNTER_BITS-1:0] bit_count_r;
  work_t      chain_r;
  work_t      work_r;

  logic       in_fire;
  logic       out_fire;
  logic       last_word;
  logic       wrap;
  logic       restart;
  logic       restart_mode;
  logic       append_en;
  logic       round_en;
  word_t      app_word;
  word_t      masked_word;
  word_t      wt;
  work_t      round_out;
  logic [3:0] sat_nb;
  logic [6:0] add_bits;
  logic [LEN_FIELD_BITS-1:0] len_ext;
  sched_ctl_t sched_ctl;

  assign in_fire   = in_msg.valid && in_msg.ready;
  assign out_fire  = out_dig.valid && out_dig.ready;
  assign last_word = (idx_r == (mode_r ? LAST_IDX_384 : LAST_IDX_512));
  assign wrap      = append_en && (fill_r == FILL_LAST);

  // A configuration write and the end of a digest both restart the message.
  assign restart      = cfg_wr_en || (out_fire && last_word);
  assign restart_mode = cfg_wr_en ? cfg_wr_data : mode_r;

  // Byte count of the final word saturates at eight; non-final words are full.
  assign sat_nb   = (in_msg.valid_bytes > FULL_BYTES) ? FULL_BYTES : in_msg.valid_bytes;
  assign add_bits = in_msg.final_word ? {sat_nb, 3'b000} : {FULL_BYTES, 3'b000};
  assign len_ext  = LEN_FIELD_BITS'(bit_count_r);

  // Final word: keep the valid leading bytes, put the pad mark right after
  // them and clear the rest. With eight valid bytes the mark goes in a word
  // of its own.
  always_comb begin
    masked_word = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < sat_nb) begin
        masked_word[63 - 8 * i -: 8] = in_msg.msg_word[63 - 8 * i -: 8];
      end else if (4'(i) == sat_nb) begin
        masked_word[63 - 8 * i -: 8] = PAD_MARK_BYTE;
      end
    end
  end

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (wrap) begin
            state_nxt = ST_ROUND;
          end else if (in_msg.final_word) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_ROUND: begin
        if (rcnt_r == RCNT_LAST) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        if (!fin_r) begin
          state_nxt = ST_IDLE;
        end else if (step_r == PAD_DONE) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_PAD;
        end
      end
      ST_PAD: begin
        if (wrap) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_OUT: begin
        if (out_fire && last_word) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs: which word goes into the block and whether a round runs.
  always_comb begin
    append_en = 1'b0;
    round_en  = 1'b0;
    app_word  = '0;
    step_nxt  = step_r;
    case (state_r)
      ST_IDLE: begin
        append_en = in_fire;
        app_word  = in_msg.final_word ? masked_word : in_msg.msg_word;
        if (in_fire && in_msg.final_word) begin
          step_nxt = (sat_nb == FULL_BYTES) ? PAD_MARK : PAD_ZERO;
        end
      end
      ST_ROUND: begin
        round_en = 1'b1;
      end
      ST_PAD: begin
        append_en = 1'b1;
        case (step_r)
          PAD_MARK: begin
            app_word = {PAD_MARK_BYTE, 56'h0};
            step_nxt = PAD_ZERO;
          end
          PAD_ZERO: begin
            // Zero fill stops two words short of the block end, where the
            // 128-bit length goes, high word first.
            if (fill_r == FILL_LEN_SLOT) begin
              app_word = len_ext[127:64];
              step_nxt = PAD_LEN_LO;
            end
          end
          PAD_LEN_LO: begin
            app_word = len_ext[63:0];
            step_nxt = PAD_DONE;
          end
          default: begin
            append_en = 1'b0;
          end
        endcase
      end
      default: begin
        append_en = 1'b0;
      end
    endcase
  end

  assign sched_ctl.shift  = append_en || round_en;
  assign sched_ctl.expand = round_en;

  sha512_sched u_sched (
    .clk      (clk),
    .ctl      (sched_ctl),
    .app_word (app_word),
    .wt       (wt)
  );

  sha512_round u_round (
    .cur (work_r),
    .kt  (ROUND_K[rcnt_r]),
    .wt  (wt),
    .nxt (round_out)
  );

  // Control state and chaining value.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= PAD_ZERO;
      mode_r      <= 1'b0;
      fin_r       <= 1'b0;
      fill_r      <= '0;
      idx_r       <= '0;
      rcnt_r      <= '0;
      bit_count_r <= '0;
      chain_r     <= IV_512;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;

      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end

      if (restart) begin
        fin_r <= 1'b0;
      end else if (in_fire && in_msg.final_word) begin
        fin_r <= 1'b1;
      end

      if (restart) begin
        fill_r <= '0;
      end else if (append_en) begin
        fill_r <= fill_r + 4'd1;
      end

      if (restart) begin
        bit_count_r <= '0;
      end else if (in_fire) begin
        bit_count_r <= bit_count_r + LENGTH_COUNTER_BITS'(add_bits);
      end

      if (wrap) begin
        rcnt_r <= '0;
      end else if (round_en) begin
        rcnt_r <= rcnt_r + RCNT_W'(1);
      end

      if (out_fire) begin
        idx_r <= last_word ? 3'd0 : idx_r + 3'd1;
      end

      if (restart) begin
        chain_r <= restart_mode ? IV_384 : IV_512;
      end else if (state_r == ST_ADD) begin
        for (int i = 0; i < 8; i++) begin
          chain_r[i] <= chain_r[i] + work_r[i];
        end
      end
    end
  end

  // Working variables: loaded from the chain when a block fills.
  always_ff @(posedge clk) begin
    if (wrap) begin
      work_r <= chain_r;
    end else if (round_en) begin
      work_r <= round_out;
    end
  end

  assign in_msg.ready        = (state_r == ST_IDLE);
  assign out_dig.valid       = (state_r == ST_OUT);
  assign out_dig.digest_word = chain_r[idx_r];
  assign out_dig.word_index  = idx_r;
  assign out_dig.digest_last = last_word;

endmodule

@@ hw/rtl/sha512_hash_core_chk.sv @@
// ============================================================================
// SHA-512 hash core port checker
// Concurrent checks on the channel ports, bound to the top level.
// ============================================================================
module sha512_hash_core_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] digest_word,
  input logic [2:0]  word_index,
  input logic        digest_last
);

  // The core never takes a word while a digest is pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while digest is being delivered");

  // Digest words follow each other with rising index until the last one.
  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !digest_last |=>
      out_valid && (word_index == $past(word_index) + 3'd1))
    else $error("digest word sequence broken");

  // The last word sits at index 5 or 7 depending on the mode.
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && digest_last |-> (word_index == 3'd5 || word_index == 3'd7))
    else $error("digest ends at an unexpected index");

  // A stalled digest word holds its value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(digest_word))
    else $error("stalled digest word changed");

  // Coming out of reset the core is ready for a message.
  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("core not idle after reset");

endmodule

bind sha512_hash_core sha512_hash_core_chk u_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_msg.ready),
  .out_valid   (out_dig.valid),
  .out_ready   (out_dig.ready),
  .digest_word (out_dig.digest_word),
  .word_index  (out_dig.word_index),
  .digest_last (out_dig.digest_last)
);
